// ===== rtl/foc_pkg.sv =====
package foc_pkg;

	localparam int DataW = 16;
	localparam int ErrW = 17;
	localparam int DiffW = ErrW + 3;
	localparam int AccW = 48;
	localparam int MulW = 20;

	localparam logic signed [AccW-1:0] SatHi = AccW'(32767);
	localparam logic signed [AccW-1:0] SatLo = -AccW'(32768);
	localparam logic signed [DiffW-1:0] ErrHi = DiffW'(65535);
	localparam logic signed [DiffW-1:0] ErrLo = -DiffW'(65536);

	localparam logic [2:0] RegTorqueKp = 3'd0;
	localparam logic [2:0] RegTorqueKi = 3'd1;
	localparam logic [2:0] RegFluxKp = 3'd2;
	localparam logic [2:0] RegFluxKi = 3'd3;
	localparam logic [2:0] RegTorqueRef = 3'd4;
	localparam logic [2:0] RegFluxRef = 3'd5;

	function automatic logic signed [AccW-1:0] rnd_sh(input logic signed [AccW-1:0] v,
			input int n);
		logic signed [AccW-1:0] t;
		begin
			t = v + (AccW'(1) <<< (n - 1));
			return t >>> n;
		end
	endfunction

	function automatic logic signed [DataW-1:0] sat16(input logic signed [AccW-1:0] v);
		begin
			if (v > SatHi) return 16'sh7fff;
			if (v < SatLo) return 16'sh8000;
			return v[DataW-1:0];
		end
	endfunction

	function automatic logic ovf16(input logic signed [AccW-1:0] v);
		begin
			return (v > SatHi) || (v < SatLo);
		end
	endfunction

	function automatic logic signed [ErrW-1:0] sat_err(input logic signed [DiffW-1:0] d);
		begin
			if (d > ErrHi) return ErrW'(65535);
			if (d < ErrLo) return ErrW'(-65536);
			return d[ErrW-1:0];
		end
	endfunction

endpackage

// ===== rtl/foc_mac.sv =====
module foc_mac (
	input logic clk,
	input logic arst_n,
	input logic clr,
	input logic acc_en,
	input logic neg,
	input logic signed [foc_pkg::MulW-1:0] op_a,
	input logic signed [foc_pkg::MulW-1:0] op_b,
	output logic signed [foc_pkg::AccW-1:0] acc
);
	import foc_pkg::*;

	logic signed [AccW-1:0] acc_q;
	logic signed [2*MulW-1:0] prod;

	assign prod = op_a * op_b;
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (acc_en) begin
			if (clr) begin
				acc_q <= neg ? -AccW'(prod) : AccW'(prod);
			end else begin
				acc_q <= neg ? acc_q - AccW'(prod) : acc_q + AccW'(prod);
			end
		end
	end
endmodule

// ===== rtl/foc_current_regulator_core.sv =====
// channel  | handshake             | payload
// s_axis   | s_axis_tvalid/tready  | tdata: phase_a, phase_b, angle; tuser: restart
// m_axis   | m_axis_tvalid/tready  | tdata: voltage_alpha, voltage_beta; tuser: clipped
// cfg      | cfg_we, cfg_idx       | cfg_data: gain and target registers
// a request runs 26 sequencer steps through the single shared multiplier, so the
// next request is taken only after the previous result is loaded; s_axis_tready is low meanwhile
// the result lands in the output register in the last step, StDone
// if that register is still full the last step waits until m_axis_tready frees it
// reset clears all registers and the pi history
module foc_current_regulator_core #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// phase_a_current, phase_b_current, electrical_angle, zero fill
	input logic [((2*SAMPLE_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
	// restart
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// voltage_alpha, voltage_beta
	output logic [31:0] m_axis_tdata,
	// clipped
	output logic m_axis_tuser,
	input logic cfg_we,
	input logic [2:0] cfg_idx,
	input logic [15:0] cfg_data
);
	import foc_pkg::*;

	localparam int Sh = 16 - SINE_TABLE_BITS;

	localparam logic [4:0] StSinSq = 5'd0;
	localparam logic [4:0] StSinU2 = 5'd1;
	localparam logic [4:0] StSinT = 5'd2;
	localparam logic [4:0] StSinS = 5'd3;
	localparam logic [4:0] StSinCap = 5'd4;
	localparam logic [4:0] StCosSq = 5'd5;
	localparam logic [4:0] StCosU2 = 5'd6;
	localparam logic [4:0] StCosT = 5'd7;
	localparam logic [4:0] StCosS = 5'd8;
	localparam logic [4:0] StCosCap = 5'd9;
	localparam logic [4:0] StBeta = 5'd10;
	localparam logic [4:0] StIdA = 5'd11;
	localparam logic [4:0] StIdB = 5'd12;
	localparam logic [4:0] StIqA = 5'd13;
	localparam logic [4:0] StIqB = 5'd14;
	localparam logic [4:0] StIqDone = 5'd15;
	localparam logic [4:0] StPiqA = 5'd16;
	localparam logic [4:0] StPiqB = 5'd17;
	localparam logic [4:0] StPidA = 5'd18;
	localparam logic [4:0] StPidB = 5'd19;
	localparam logic [4:0] StPidDone = 5'd20;
	localparam logic [4:0] StVaA = 5'd21;
	localparam logic [4:0] StVaB = 5'd22;
	localparam logic [4:0] StVbA = 5'd23;
	localparam logic [4:0] StVbB = 5'd24;
	localparam logic [4:0] StDone = 5'd25;

	logic [15:0] kpq_q, kiq_q, kpd_q, kid_q;
	logic signed [15:0] tq_q, td_q;
	logic signed [ErrW-1:0] eq_last_q, ed_last_q;
	logic signed [15:0] yq_last_q, yd_last_q;
	logic signed [15:0] ia_q, ib_q, sn_q, cs_q, vd_q, vq_q, va_q;
	logic signed [ErrW-1:0] beta_q;
	logic signed [ErrW:0] id_q, iq_q;
	logic [MulW-1:0] u2_q;
	logic [15:0] ang_q;
	logic busy_q, clip_q, ovalid_q;
	logic [4:0] step_q;
	logic [31:0] odata_q;
	logic oclip_q;

	logic mclr, men, mneg;
	logic signed [MulW-1:0] ma, mb;
	logic signed [AccW-1:0] acc;

	foc_mac u_mac (.clk(clk), .arst_n(arst_n), .clr(mclr), .acc_en(men), .neg(mneg),
		.op_a(ma), .op_b(mb), .acc(acc));

	logic signed [SAMPLE_WIDTH-1:0] ra, rb;
	logic signed [15:0] qa, qb;
	assign ra = s_axis_tdata[SAMPLE_WIDTH-1:0];
	assign rb = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	if (SAMPLE_WIDTH >= 16) begin : g_narrow
		assign qa = 16'(ra >>> (SAMPLE_WIDTH - 16));
		assign qb = 16'(rb >>> (SAMPLE_WIDTH - 16));
	end else begin : g_widen
		assign qa = 16'(ra) <<< (16 - SAMPLE_WIDTH);
		assign qb = 16'(rb) <<< (16 - SAMPLE_WIDTH);
	end

	// sine: u for sin in steps 0..4, for cos in steps 5..9
	logic [15:0] ang_c;
	logic [14:0] u_c;
	assign ang_c = (step_q >= StCosSq) ? ang_q + 16'd16384 : ang_q;
	assign u_c = ang_c[14] ? 15'd16384 - {1'b0, ang_c[13:0]} : {1'b0, ang_c[13:0]};

	logic signed [AccW-1:0] acc14, rnd12, rnd15, ysum;
	logic [MulW-1:0] t_c;
	logic signed [15:0] s_mag, s_c, ysat, vsat;
	logic yovf, vovf;
	logic signed [ErrW-1:0] eq_c, ed_c;
	logic out_load;

	assign acc14 = acc >>> 14;
	assign t_c = acc14[MulW-1:0];
	assign s_mag = (acc14 > SatHi) ? 16'sd32767 : acc14[15:0];
	assign s_c = ang_c[15] ? -s_mag : s_mag;

	assign rnd12 = rnd_sh(acc, 12);
	assign rnd15 = rnd_sh(acc, 15);
	assign ysum = AccW'(step_q == StPidA ? yq_last_q : yd_last_q) + rnd12;
	assign ysat = sat16(ysum);
	assign yovf = ovf16(ysum);
	assign vsat = sat16(rnd15);
	assign vovf = ovf16(rnd15);

	assign eq_c = sat_err(DiffW'(tq_q) - DiffW'(iq_q));
	assign ed_c = sat_err(DiffW'(td_q) - DiffW'(id_q));

	// sequencer: at most one multiply per step
	always_comb begin
		mclr = 1'b1;
		men = busy_q;
		mneg = 1'b0;
		ma = '0;
		mb = '0;
		case (step_q)
			StSinSq, StCosSq: begin ma = MulW'(u_c); mb = MulW'(u_c); end
			StSinU2, StCosU2: begin ma = t_c; mb = MulW'(2320); end
			StSinT, StCosT: begin ma = MulW'(21024) - t_c; mb = u2_q; end
			StSinS, StCosS: begin ma = MulW'(51472) - t_c; mb = MulW'(u_c); end
			StBeta: begin ma = MulW'(ia_q) + (MulW'(ib_q) <<< 1); mb = MulW'(18919); end
			StIdA: begin ma = MulW'(ia_q); mb = MulW'(cs_q); end
			StIdB: begin ma = MulW'(beta_q); mb = MulW'(sn_q); mclr = 1'b0; end
			StIqA: begin ma = MulW'(beta_q); mb = MulW'(cs_q); end
			StIqB: begin ma = MulW'(ia_q); mb = MulW'(sn_q); mclr = 1'b0; mneg = 1'b1; end
			StPiqA: begin ma = MulW'({1'b0, kpq_q}) + MulW'({1'b0, kiq_q});
				mb = MulW'(eq_c); end
			StPiqB: begin ma = MulW'({1'b0, kpq_q}); mb = MulW'(eq_last_q);
				mclr = 1'b0; mneg = 1'b1; end
			StPidA: begin ma = MulW'({1'b0, kpd_q}) + MulW'({1'b0, kid_q});
				mb = MulW'(ed_c); end
			StPidB: begin ma = MulW'({1'b0, kpd_q}); mb = MulW'(ed_last_q);
				mclr = 1'b0; mneg = 1'b1; end
			StVaA: begin ma = MulW'(vd_q); mb = MulW'(cs_q); end
			StVaB: begin ma = MulW'(vq_q); mb = MulW'(sn_q); mclr = 1'b0; mneg = 1'b1; end
			StVbA: begin ma = MulW'(vd_q); mb = MulW'(sn_q); end
			StVbB: begin ma = MulW'(vq_q); mb = MulW'(cs_q); mclr = 1'b0; end
			default: men = 1'b0;
		endcase
	end

	assign out_load = busy_q && (step_q == StDone) && (!ovalid_q || m_axis_tready);

	assign s_axis_tready = !busy_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign m_axis_tuser = oclip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kpq_q <= '0; kiq_q <= '0; kpd_q <= '0; kid_q <= '0;
			tq_q <= '0; td_q <= '0;
			eq_last_q <= '0; ed_last_q <= '0; yq_last_q <= '0; yd_last_q <= '0;
			busy_q <= 1'b0; step_q <= '0; ovalid_q <= 1'b0;
			clip_q <= 1'b0; oclip_q <= 1'b0; odata_q <= '0;
			ia_q <= '0; ib_q <= '0; sn_q <= '0; cs_q <= '0; beta_q <= '0;
			id_q <= '0; iq_q <= '0; vd_q <= '0; vq_q <= '0; va_q <= '0; u2_q <= '0;
			ang_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					RegTorqueKp: kpq_q <= cfg_data;
					RegTorqueKi: kiq_q <= cfg_data;
					RegFluxKp: kpd_q <= cfg_data;
					RegFluxKi: kid_q <= cfg_data;
					RegTorqueRef: tq_q <= cfg_data;
					RegFluxRef: td_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				busy_q <= 1'b1;
				step_q <= StSinSq;
				clip_q <= 1'b0;
				ia_q <= qa;
				ib_q <= qb;
				ang_q <= (s_axis_tdata[2*SAMPLE_WIDTH+15:2*SAMPLE_WIDTH] >> Sh) << Sh;
				if (s_axis_tuser) begin
					eq_last_q <= '0; ed_last_q <= '0; yq_last_q <= '0; yd_last_q <= '0;
				end
			end else if (busy_q) begin
				if (step_q != StDone) step_q <= step_q + 5'd1;
				case (step_q)
					StSinU2, StCosU2: u2_q <= t_c;
					StSinCap: sn_q <= s_c;
					StCosCap: cs_q <= s_c;
					StIdA: beta_q <= rnd15[ErrW-1:0];
					StIqA: id_q <= rnd15[ErrW:0];
					StIqDone: iq_q <= rnd15[ErrW:0];
					StPiqB: eq_last_q <= eq_c;
					StPidA: begin
						vq_q <= ysat; yq_last_q <= ysat; clip_q <= clip_q | yovf;
					end
					StPidB: ed_last_q <= ed_c;
					StPidDone: begin
						vd_q <= ysat; yd_last_q <= ysat; clip_q <= clip_q | yovf;
					end
					StVbA: begin
						va_q <= vsat; clip_q <= clip_q | vovf;
					end
					StDone: begin
						if (out_load) begin
							odata_q <= {vsat, va_q};
							oclip_q <= clip_q | vovf;
							busy_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule
